// File: rtl/ved_pkg.sv
`default_nettype none
package ved_pkg;

  // Default width of one velocity difference and of the result
  localparam int unsigned DataWidthDefault = 32;

  // Differences are brought down to this many magnitude bits before the products
  localparam int unsigned NormBits = 14;

  // Fixed right shift of the final product before the normalization shift is
  // added back: Q0.32 coefficient, Q16.16 spacing, 2^32 quotient scale, half.
  localparam int unsigned ScaleShift = 65;

  localparam int unsigned CfgIndexWidth = 8;
  localparam int unsigned RegWidth      = 32;

  localparam logic [CfgIndexWidth-1:0] CfgCoefficient    = 8'd0;
  localparam logic [CfgIndexWidth-1:0] CfgInverseSpacing = 8'd1;

  localparam logic [RegWidth-1:0] CoefficientReset    = 32'd300647710;
  localparam logic [RegWidth-1:0] InverseSpacingReset = 32'd65536;

  // Columns of the gradient tensor that form each distinct entry of
  // beta: b00, b11, b22, b01, b02, b12
  localparam int unsigned BetaCol0 [6] = '{0, 1, 2, 0, 0, 1};
  localparam int unsigned BetaCol1 [6] = '{0, 1, 2, 1, 2, 2};

endpackage
`default_nettype wire

// File: rtl/vreman_eddy_viscosity.sv
`default_nettype none
// Vreman subgrid eddy viscosity, one grid cell per beat. The input beat carries
// the nine central velocity differences of a cell (Q16.16 at the default width);
// the output beat carries nu_t = Cv * sqrt(B / |alpha|^2) in unsigned Q16.16
// with a saturation flag in tuser. The block is a fixed pipeline of 107 register
// stages, and a new cell can be accepted in every cycle while the output side
// does not stall. Its length is set by the restoring divider (64 stages, one
// quotient bit each) and the integer square root (32 stages, one root bit
// each); eleven further stages form magnitudes, normalize, build the tensor
// products, scale the root and register the output. The whole pipeline holds
// while a finished result waits on m_axis_tready.
// Registers: index 0 holds Cv (unsigned Q0.32), index 1 holds 1/h (unsigned
// Q16.16); other indexes are ignored. Write them only while the pipe is empty.
module vreman_eddy_viscosity #(
  parameter int unsigned DATA_WIDTH = ved_pkg::DataWidthDefault
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // cfg write channel
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [ved_pkg::CfgIndexWidth-1:0]       cfg_index_i,
  input  wire logic [ved_pkg::RegWidth-1:0]            cfg_data_i,
  // tdata, low bit up: du_along_x, dv_along_x, dw_along_x, du_along_y,
  // dv_along_y, dw_along_y, du_along_z, dv_along_z, dw_along_z, zero pad
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  // tdata, low bit up: eddy_viscosity, zero pad
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]              m_axis_tdata,
  // tuser: saturated
  output logic                                         m_axis_tuser
);
  import ved_pkg::*;

  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned InW   = ((9*DW+7)/8)*8;
  localparam int unsigned OutW  = ((DW+7)/8)*8;
  localparam int unsigned LW    = $clog2(DW+1);      // bit length / shift
  localparam int unsigned AW    = NormBits + 1;      // normalized signed value
  localparam int unsigned PW    = 2*AW;              // one product
  localparam int unsigned BW    = PW + 2;            // beta entry
  localparam int unsigned MW    = 2*BW;              // minor product
  localparam int unsigned QW    = 64;                // quotient
  localparam int unsigned RW    = QW/2;              // root
  localparam int unsigned NW    = 32;                // norm / remainder
  localparam int unsigned FW    = 96;                // full scaled product
  localparam int unsigned SHW   = 7;

  // one global advance: the pipe moves when the output register is free
  logic adv;
  logic out_valid_q;
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  // ---------------- configuration registers ----------------
  logic [RegWidth-1:0]   coef_q, inv_q;
  logic [2*RegWidth-1:0] p_q;   // Cv * (1/h), follows the registers

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= CoefficientReset;
      inv_q  <= InverseSpacingReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgCoefficient:    coef_q <= cfg_data_i;
        CfgInverseSpacing: inv_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= coef_q * inv_q;
  end

  // ---------------- stage 1: sign and magnitude ----------------
  logic          v1_q;
  logic [DW-1:0] mag1_q [9];
  logic          neg1_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= s_axis_tvalid;
  end

  for (genvar e = 0; e < 9; e++) begin : g_mag
    logic [DW-1:0] raw;
    assign raw = s_axis_tdata[e*DW +: DW];
    // the most negative value negates to itself, which is its magnitude
    always_ff @(posedge clk_i) begin
      if (adv) begin
        neg1_q[e] <= raw[DW-1];
        mag1_q[e] <= raw[DW-1] ? (~raw + 1'b1) : raw;
      end
    end
  end

  // ---------------- stage 2: normalization shift ----------------
  logic          v2_q;
  logic [DW-1:0] mag2_q [9];
  logic          neg2_q [9];
  logic [LW-1:0] s2_q;
  logic [DW-1:0] or_all;
  logic [LW-1:0] len;
  logic [LW-1:0] s2_d;

  always_comb begin
    or_all = '0;
    for (int e = 0; e < 9; e++) or_all = or_all | mag1_q[e];
    len = '0;
    for (int b = 0; b < DW; b++) begin
      if (or_all[b]) len = LW'(b + 1);
    end
    s2_d = (len > LW'(NormBits)) ? (len - LW'(NormBits)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q   <= s2_d;
      mag2_q <= mag1_q;
      neg2_q <= neg1_q;
    end
  end

  // ---------------- stage 3: normalized signed tensor ----------------
  logic                 v3_q;
  logic [LW-1:0]        s3_q;
  logic signed [AW-1:0] a3_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end

  for (genvar e = 0; e < 9; e++) begin : g_norm
    logic [DW-1:0] shifted;
    logic [AW-1:0] t;
    assign shifted = mag2_q[e] >> s2_q;
    assign t       = {1'b0, shifted[NormBits-1:0]};
    always_ff @(posedge clk_i) begin
      if (adv) a3_q[e] <= neg2_q[e] ? -t : t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) s3_q <= s2_q;
  end

  // ---------------- stage 4: column products ----------------
  logic                 v4_q;
  logic [LW-1:0]        s4_q;
  logic signed [PW-1:0] prod4_q [6][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q;
  end

  for (genvar p = 0; p < 6; p++) begin : g_prod
    for (genvar k = 0; k < 3; k++) begin : g_row
      always_ff @(posedge clk_i) begin
        if (adv) prod4_q[p][k] <= a3_q[k*3 + BetaCol0[p]] * a3_q[k*3 + BetaCol1[p]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) s4_q <= s3_q;
  end

  // ---------------- stage 5: beta entries ----------------
  logic                 v5_q;
  logic [LW-1:0]        s5_q;
  logic signed [BW-1:0] beta5_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= v4_q;
  end

  for (genvar p = 0; p < 6; p++) begin : g_beta
    always_ff @(posedge clk_i) begin
      if (adv) begin
        beta5_q[p] <= BW'(prod4_q[p][0]) + BW'(prod4_q[p][1]) + BW'(prod4_q[p][2]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) s5_q <= s4_q;
  end

  // ---------------- stage 6: minor products and norm ----------------
  logic                 v6_q;
  logic [LW-1:0]        s6_q;
  logic signed [MW-1:0] mp6_q [6];
  logic [NW-1:0]        norm6_q;
  logic [BW+1:0]        norm_sum;

  assign norm_sum = (BW+2)'(beta5_q[0]) + (BW+2)'(beta5_q[1]) + (BW+2)'(beta5_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (adv) v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_q     <= s5_q;
      norm6_q  <= norm_sum[NW-1:0];
      mp6_q[0] <= beta5_q[0] * beta5_q[1];
      mp6_q[1] <= beta5_q[3] * beta5_q[3];
      mp6_q[2] <= beta5_q[0] * beta5_q[2];
      mp6_q[3] <= beta5_q[4] * beta5_q[4];
      mp6_q[4] <= beta5_q[1] * beta5_q[2];
      mp6_q[5] <= beta5_q[5] * beta5_q[5];
    end
  end

  // ---------------- stage 7: sum of minors, divider setup ----------------
  logic                 v7_q;
  logic [LW-1:0]        s7_q;
  logic                 zero7_q;
  logic [NW-1:0]        norm7_q;
  logic [NW-1:0]        rem7_q;
  logic [QW-1:0]        low7_q;
  logic signed [MW-1:0] bsum;

  assign bsum = (mp6_q[0] - mp6_q[1]) + (mp6_q[2] - mp6_q[3]) + (mp6_q[4] - mp6_q[5]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (adv) v7_q <= v6_q;
  end

  // B is at most norm^2/3, so B >> 32 is below norm and the quotient fits
  // in 64 bits: start with that as the remainder.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_q    <= s6_q;
      zero7_q <= bsum[MW-1] || (bsum == '0);
      norm7_q <= norm6_q;
      rem7_q  <= NW'(bsum[MW-1:32]);
      low7_q  <= {bsum[31:0], 32'b0};
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  logic          dv_q    [QW];
  logic [LW-1:0] ds_q    [QW];
  logic          dz_q    [QW];
  logic [NW-1:0] dnorm_q [QW];
  logic [NW-1:0] drem_q  [QW];
  logic [QW-1:0] dlow_q  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic          pv, pz;
    logic [LW-1:0] ps;
    logic [NW-1:0] pnorm, prem;
    logic [QW-1:0] plow;
    logic [NW:0]   trial;
    logic          take;
    logic [NW:0]   diff;

    if (i == 0) begin : g_first
      assign pv = v7_q;     assign pz = zero7_q;  assign ps = s7_q;
      assign pnorm = norm7_q; assign prem = rem7_q; assign plow = low7_q;
    end else begin : g_next
      assign pv = dv_q[i-1];   assign pz = dz_q[i-1];   assign ps = ds_q[i-1];
      assign pnorm = dnorm_q[i-1]; assign prem = drem_q[i-1]; assign plow = dlow_q[i-1];
    end

    assign trial = {prem, plow[QW-1]};
    assign take  = trial >= {1'b0, pnorm};
    assign diff  = trial - {1'b0, pnorm};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[i] <= 1'b0;
      else if (adv) dv_q[i] <= pv;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dz_q[i]    <= pz;
        ds_q[i]    <= ps;
        dnorm_q[i] <= pnorm;
        drem_q[i]  <= take ? diff[NW-1:0] : trial[NW-1:0];
        dlow_q[i]  <= {plow[QW-2:0], take};
      end
    end
  end

  // ---------------- square root: one root bit per stage ----------------
  logic          qv_q    [RW];
  logic [LW-1:0] qs_q    [RW];
  logic          qz_q    [RW];
  logic [QW-1:0] qx_q    [RW];
  logic [RW+1:0] qrem_q  [RW];
  logic [RW-1:0] qroot_q [RW];

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    logic          pv, pz;
    logic [LW-1:0] ps;
    logic [QW-1:0] px;
    logic [RW+1:0] prem;
    logic [RW-1:0] proot;
    logic [RW+3:0] cand, trial;
    logic          take;
    logic [RW+3:0] diff;

    if (i == 0) begin : g_first
      assign pv = dv_q[QW-1]; assign pz = dz_q[QW-1]; assign ps = ds_q[QW-1];
      assign px = dlow_q[QW-1]; assign prem = '0; assign proot = '0;
    end else begin : g_next
      assign pv = qv_q[i-1]; assign pz = qz_q[i-1]; assign ps = qs_q[i-1];
      assign px = qx_q[i-1]; assign prem = qrem_q[i-1]; assign proot = qroot_q[i-1];
    end

    assign cand  = {prem, px[QW-1:QW-2]};
    assign trial = {2'b00, proot, 2'b01};
    assign take  = cand >= trial;
    assign diff  = cand - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) qv_q[i] <= 1'b0;
      else if (adv) qv_q[i] <= pv;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        qz_q[i]    <= pz;
        qs_q[i]    <= ps;
        qx_q[i]    <= {px[QW-3:0], 2'b00};
        qrem_q[i]  <= take ? diff[RW+1:0] : cand[RW+1:0];
        qroot_q[i] <= {proot[RW-2:0], take};
      end
    end
  end

  // ---------------- scale: partial products ----------------
  logic          m1v_q, m1z_q;
  logic [LW-1:0] m1s_q;
  logic [63:0]   m1lo_q, m1hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m1v_q <= 1'b0;
    else if (adv) m1v_q <= qv_q[RW-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1z_q  <= qz_q[RW-1];
      m1s_q  <= qs_q[RW-1];
      m1lo_q <= p_q[31:0]  * qroot_q[RW-1];
      m1hi_q <= p_q[63:32] * qroot_q[RW-1];
    end
  end

  // ---------------- scale: combine into the full product ----------------
  logic          m2v_q, m2z_q;
  logic [LW-1:0] m2s_q;
  logic [FW-1:0] m2p_q;
  logic [63:0]   mid;

  assign mid = m1hi_q + {32'b0, m1lo_q[63:32]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m2v_q <= 1'b0;
    else if (adv) m2v_q <= m1v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2z_q <= m1z_q;
      m2s_q <= m1s_q;
      m2p_q <= {mid, m1lo_q[31:0]};
    end
  end

  // ---------------- scale: shift back by the normalization ----------------
  logic          m3v_q, m3z_q;
  logic [FW-1:0] m3r_q;
  logic [SHW-1:0] sh;

  assign sh = SHW'(ScaleShift) - SHW'(m2s_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m3v_q <= 1'b0;
    else if (adv) m3v_q <= m2v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m3z_q <= m2z_q;
      m3r_q <= m2p_q >> sh;
    end
  end

  // ---------------- output register: saturate ----------------
  logic          sat;
  logic [DW-1:0] out_d;
  logic [DW-1:0] out_q;
  logic          sat_q;

  always_comb begin
    sat   = !m3z_q && (|m3r_q[FW-1:DW]);
    out_d = m3z_q ? '0 : (sat ? '1 : m3r_q[DW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= m3v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
      sat_q <= sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(out_q);
  assign m_axis_tuser  = sat_q;

endmodule
`default_nettype wire

// File: tb/vreman_eddy_viscosity_test.sv
module vreman_eddy_viscosity_test;
  import ved_pkg::*;

  localparam int unsigned Dw = 32;
  localparam int unsigned InW = ((9 * Dw + 7) / 8) * 8;
  localparam int unsigned OutW = ((Dw + 7) / 8) * 8;
  // pipeline depth is 107; leave slack for the drain
  localparam int unsigned PipeDepth = 107;
  localparam int unsigned CycleLimit = 600000;

  typedef struct packed {
    logic [Dw-1:0] viscosity;
    logic          clipped;
  } nu_beat_t;

  // Tracks the predicted viscosity of every accepted cell, oldest first.
  class ViscosityScoreboard;
    logic [RegWidth-1:0] coefficient = CoefficientReset;
    logic [RegWidth-1:0] spacing     = InverseSpacingReset;
    nu_beat_t            predicted_q[$];
    int                  errors = 0;

    function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [RegWidth-1:0] val);
      if (idx == CfgCoefficient) coefficient = val;
      else if (idx == CfgInverseSpacing) spacing = val;
    endfunction

    function logic [63:0] int_root(logic [63:0] x);
      logic [63:0] acc, bit_w;
      acc = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > x) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
        if (x >= acc + bit_w) begin
          x = x - (acc + bit_w);
          acc = (acc >> 1) + bit_w;
        end else begin
          acc = acc >> 1;
        end
        bit_w = bit_w >> 2;
      end
      return acc;
    endfunction

    // Predict the result of one accepted cell.
    function void note_cell(logic [InW-1:0] diffs);
      logic [Dw-1:0] v;
      logic [63:0]   mag [9];
      bit            neg [9];
      longint        grad [9];
      longint        beta [3][3];
      logic [63:0]   peak, norm, bb, q0, rem, quot, root, prod, plo, phi, lo, mid, res;
      longint        minors, acc;
      int            len, s;
      nu_beat_t      nb;
      peak = 0;
      for (int i = 0; i < 9; i++) begin
        v = diffs[i*Dw +: Dw];
        neg[i] = v[Dw-1];
        // the most negative value negates to itself, which is its magnitude
        mag[i] = neg[i] ? {32'd0, Dw'(~v + 1'b1)} : {32'd0, v};
        if (mag[i] > peak) peak = mag[i];
      end
      len = 0;
      while (len < 64 && (peak >> len) != 0) len++;
      s = (len > NormBits) ? len - NormBits : 0;
      for (int i = 0; i < 9; i++)
        grad[i] = neg[i] ? -longint'(mag[i] >> s) : longint'(mag[i] >> s);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += grad[k*3+i] * grad[k*3+j];
          beta[i][j] = acc;
        end
      norm = beta[0][0] + beta[1][1] + beta[2][2];
      minors = (beta[0][0] * beta[1][1] - beta[0][1] * beta[0][1])
             + (beta[0][0] * beta[2][2] - beta[0][2] * beta[0][2])
             + (beta[1][1] * beta[2][2] - beta[1][2] * beta[1][2]);
      nb = '0;
      if (norm != 0 && spacing != 0 && minors > 0) begin
        bb = minors;
        q0 = bb / norm;
        rem = bb % norm;
        quot = (q0 << 32) + ((rem << 32) / norm);
        root = int_root(quot);
        prod = {32'd0, coefficient} * {32'd0, spacing};
        plo = prod & 64'hFFFF_FFFF;
        phi = prod >> 32;
        lo = plo * root;
        mid = phi * root + (lo >> 32);
        // s never exceeds 18, so the total shift stays at 47 or more
        res = mid >> (ScaleShift - s - 32);
        if (res > 64'hFFFF_FFFF) begin
          nb.viscosity = '1;
          nb.clipped = 1'b1;
        end else begin
          nb.viscosity = res[Dw-1:0];
        end
      end
      predicted_q.push_back(nb);
    endfunction

    function void check_beat(logic [Dw-1:0] viscosity, logic clipped);
      nu_beat_t want;
      if (predicted_q.size() == 0) begin
        $error("result beat with no cell pending: eddy_viscosity %h", viscosity);
        errors++;
        return;
      end
      want = predicted_q.pop_front();
      if (viscosity !== want.viscosity) begin
        $error("eddy_viscosity expected %h actual %h", want.viscosity, viscosity);
        errors++;
      end
      if (clipped !== want.clipped) begin
        $error("saturated expected %b actual %b", want.clipped, clipped);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [RegWidth-1:0]      cfg_data_i = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // tdata, low bit up: du/dv/dw along x, du/dv/dw along y, du/dv/dw along z
  logic [InW-1:0]           s_axis_tdata = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // tdata, low bit up: eddy_viscosity
  logic [OutW-1:0]          m_axis_tdata;
  // tuser: saturated
  logic                     m_axis_tuser;

  ViscosityScoreboard sb = new();
  bit                 no_idle = 1'b0;  // suppress idling on both sides
  int unsigned        cycles = 0;

  vreman_eddy_viscosity #(.DATA_WIDTH(Dw)) uut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Stall the output side at random; compare every accepted result beat.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (m_axis_tvalid && m_axis_tready)
      sb.check_beat(m_axis_tdata[Dw-1:0], m_axis_tuser);
    m_axis_tready <= no_idle || ($urandom_range(99) >= 14);
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("vreman_eddy_viscosity_test: errors");
      $finish;
    end
  end

  // Offer one cell, idling first at random; hold tvalid high when no gap is taken.
  task automatic send_cell(logic [InW-1:0] diffs);
    if (!no_idle && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= diffs;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_cell(diffs);
  endtask

  // Drop tvalid and wait for every pending result, then let the pipe empty.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (sb.predicted_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [RegWidth-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [Dw-1:0] pick_diff(int unsigned range_kind);
    logic [Dw-1:0] mag;
    case (range_kind)
      0: return $urandom();
      1: mag = $urandom_range(16383);
      2: mag = $urandom() >> $urandom_range(31);
      3: return $urandom_range(3) == 0 ? '0 : $urandom();
      default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
    return $urandom_range(1) ? -mag : mag;
  endfunction

  function automatic logic [InW-1:0] random_cell();
    logic [InW-1:0] diffs;
    int unsigned    kind;
    diffs = '0;
    kind = $urandom_range(9);
    if (kind > 4) kind = $urandom_range(2);
    for (int i = 0; i < 9; i++) diffs[i*Dw +: Dw] = pick_diff(kind);
    return diffs;
  endfunction

  function automatic logic [InW-1:0] fill_cell(logic [Dw-1:0] d);
    logic [InW-1:0] diffs;
    diffs = '0;
    for (int i = 0; i < 9; i++) diffs[i*Dw +: Dw] = d;
    return diffs;
  endfunction

  logic [RegWidth-1:0] coef_set [6] = '{32'hFFFF_FFFF, 32'd0, 32'd300647710,
                                        32'd1, 32'h8000_0000, CoefficientReset};
  logic [RegWidth-1:0] spc_set  [6] = '{32'hFFFF_FFFF, 32'd65536, 32'd0,
                                        32'd1, 32'h0010_0000, InverseSpacingReset};

  initial begin
    logic [InW-1:0] diffs;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed cells under the reset configuration.
    send_cell('0);                            // zero norm
    send_cell(fill_cell(32'h7FFF_FFFF));      // largest positive, rank one
    send_cell(fill_cell(32'h8000_0000));      // most negative everywhere
    send_cell(fill_cell(32'hFFFF_FFFF));
    diffs = '0; diffs[0 +: Dw] = 32'h0001_0000;
    send_cell(diffs);                         // single entry: minors zero
    diffs = '0;
    diffs[0*Dw +: Dw] = 32'h0001_0000;
    diffs[4*Dw +: Dw] = 32'h0001_0000;
    diffs[8*Dw +: Dw] = 32'h0001_0000;
    send_cell(diffs);                         // identity tensor
    diffs[4*Dw +: Dw] = 32'h8000_0000;
    send_cell(diffs);                         // most negative beside small values
    diffs = '0;
    for (int i = 0; i < 9; i++) diffs[i*Dw +: Dw] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    send_cell(diffs);
    for (int i = 0; i < 9; i++) diffs[i*Dw +: Dw] = i + 1;
    send_cell(diffs);                         // tiny, lossless
    for (int i = 0; i < 12; i++) send_cell(random_cell());

    // Random phases, each under a new register setting.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(CfgCoefficient, ph == 3 ? $urandom() : coef_set[ph]);
      write_reg(CfgInverseSpacing, ph == 3 ? $urandom() : spc_set[ph]);
      no_idle = (ph == 2);
      for (int n = 0; n < 300; n++) send_cell(random_cell());
    end
    no_idle = 1'b0;
    drain();

    if (sb.errors == 0 && sb.predicted_q.size() == 0) begin
      $display("vreman_eddy_viscosity_test: clean");
    end else begin
      $display("vreman_eddy_viscosity_test: errors");
    end
    $finish;
  end

endmodule
